>>> rtl/core/b64fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_pkg: shared definitions of the base64 field decoder
// Result kinds, error codes, character codes and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64fd_pkg;

	// Result kind codes.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Error codes, meaningful when the kind is KIND_ERR.
	localparam logic [1:0] ERR_INVALID  = 2'd0;
	localparam logic [1:0] ERR_DANGLING = 2'd1;
	localparam logic [1:0] ERR_PAREN    = 2'd2;
	localparam logic [1:0] ERR_DEPTH    = 2'd3;

	// Character codes with a role of their own.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Alphabet lookup result.
	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// Maps a character to its six-bit value; ok is low outside the alphabet.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == CH_PLUS) begin
			r.val = 6'd62;
		end else if (c == CH_SLASH) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/base64_field_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_field_decoder: base64 decoder for zone-file record fields
// Decodes one text character per beat into data bytes, end markers and errors.
// ----------------------------------------------------------------------------
// Usage:
//   The character channel (char_valid, char_stall, char_byte) takes one raw
//   character per beat. Spaces, tabs, parentheses and ';' comments are
//   skipped; data characters gather into quartets. The result channel
//   (res_valid, res_stall, kind, data_byte, error_code, last) gives the
//   results that each character causes, last marking the final one.
//   The results of a character are registered, and the first appears in
//   the cycle after the character is accepted. One character is taken per
//   cycle while the receiver does not stall; a character that completes a
//   quartet of two or three bytes holds the input while the single result
//   register drains them one byte per beat. Reset clears the pending
//   quartet, parenthesis depth and comment flag, and empties the result
//   register. While the receiver stalls, the current result holds and no
//   new character is taken once the register is full.
// ----------------------------------------------------------------------------
module base64_field_decoder
	import b64fd_pkg::*;
#(
	parameter int MAX_PAREN_DEPTH = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [1:0] error_code,
	output logic       last
);

	localparam int DW = $clog2(MAX_PAREN_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_PAREN_DEPTH);

	// Decoder state.
	logic [17:0]   accum_q, accum_n;
	logic [1:0]    pend_q, pend_n;
	logic [1:0]    pad_q, pad_n;
	logic [DW-1:0] depth_q, depth_n;
	logic          cmt_q, cmt_n;

	// Result register: up to three results of one character.
	logic            valid_s1;
	logic [1:0]      kind_s1, code_s1;
	logic [2:0][7:0] bytes_s1;
	logic [1:0]      cnt_s1;
	logic [1:0]      idx_q;

	// Decode outputs for the current character.
	logic [1:0]      r_n;
	logic [1:0]      r_kind, r_code;
	logic [2:0][7:0] r_bytes;
	sextet_t         sx;
	logic [5:0]      sx_val;
	logic [23:0]     word;
	logic            is_pad, bad;

	logic accept, out_fire, out_done;

	assign out_fire   = valid_s1 && !res_stall;
	assign out_done   = out_fire && (idx_q == cnt_s1 - 2'd1);
	assign char_stall = valid_s1 && !out_done;
	assign accept     = char_valid && !char_stall;

	// Per-character decode and next state.
	always_comb begin
		accum_n = accum_q;
		pend_n  = pend_q;
		pad_n   = pad_q;
		depth_n = depth_q;
		cmt_n   = cmt_q;
		r_n     = 2'd0;
		r_kind  = KIND_DATA;
		r_code  = ERR_INVALID;
		r_bytes = '0;
		sx      = sextet_of(char_byte);
		is_pad  = (char_byte == CH_PAD);
		bad     = is_pad ? (pend_q < 2'd2) : (!sx.ok || pad_q != 2'd0);
		sx_val  = is_pad ? 6'd0 : sx.val;
		word    = {accum_q, sx_val};

		if (char_byte == CH_CR || char_byte == CH_LF) begin
			cmt_n = 1'b0;
			if (depth_q == '0) begin
				r_n = 2'd1;
				if (pend_q != 2'd0) begin
					r_kind = KIND_ERR;
					r_code = ERR_DANGLING;
				end else begin
					r_kind = KIND_END;
				end
			end
		end else if (cmt_q) begin
			// Characters inside a comment are dropped.
		end else if (char_byte == CH_SEMI) begin
			cmt_n = 1'b1;
		end else if (char_byte == CH_SPACE || char_byte == CH_TAB) begin
			// Separators are dropped.
		end else if (char_byte == CH_OPEN) begin
			if (depth_q >= DEPTH_MAX) begin
				depth_n = DEPTH_MAX;
				r_n     = 2'd1;
				r_kind  = KIND_ERR;
				r_code  = ERR_DEPTH;
			end else begin
				depth_n = depth_q + 1'b1;
			end
		end else if (char_byte == CH_CLOSE) begin
			if (depth_q == '0) begin
				r_n    = 2'd1;
				r_kind = KIND_ERR;
				r_code = ERR_PAREN;
			end else begin
				depth_n = depth_q - 1'b1;
			end
		end else if (bad) begin
			r_n    = 2'd1;
			r_kind = KIND_ERR;
			r_code = ERR_INVALID;
		end else begin
			pad_n = pad_q + {1'b0, is_pad};
			if (pend_q != 2'd3) begin
				accum_n = word[17:0];
				pend_n  = pend_q + 2'd1;
			end else begin
				r_n     = 2'd3 - pad_n;
				r_bytes = {word[7:0], word[15:8], word[23:16]};
			end
		end

		// Any result ends the pending quartet.
		if (r_n != 2'd0) begin
			accum_n = '0;
			pend_n  = 2'd0;
			pad_n   = 2'd0;
		end
	end

	// State registers advance on every accepted character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			pend_q  <= 2'd0;
			pad_q   <= 2'd0;
			depth_q <= '0;
			cmt_q   <= 1'b0;
		end else if (accept) begin
			accum_q <= accum_n;
			pend_q  <= pend_n;
			pad_q   <= pad_n;
			depth_q <= depth_n;
			cmt_q   <= cmt_n;
		end
	end

	// Result register control: load on a productive character, drain per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (accept && r_n != 2'd0) begin
			valid_s1 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (out_done) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept && r_n != 2'd0) begin
			kind_s1  <= r_kind;
			code_s1  <= (r_kind == KIND_ERR) ? r_code : ERR_INVALID;
			bytes_s1 <= r_bytes;
			cnt_s1   <= r_n;
		end
	end

	// Output selection of the current beat.
	always_comb begin
		case (idx_q)
			2'd0:    data_byte = bytes_s1[0];
			2'd1:    data_byte = bytes_s1[1];
			2'd2:    data_byte = bytes_s1[2];
			default: data_byte = 8'd0;
		endcase
	end

	assign res_valid  = valid_s1;
	assign kind       = kind_s1;
	assign error_code = code_s1;
	assign last       = (idx_q == cnt_s1 - 2'd1);

endmodule

>>> rtl/core/b64fd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_checker: port-level checks of the base64 field decoder
// Watches the result channel for well-formed results and stable stalls.
// ----------------------------------------------------------------------------
module b64fd_checker
	import b64fd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic [1:0] error_code,
	input logic       last
);

	// End markers and errors are always the only result of their character.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_DATA |-> last)
		else $error("end or error result without last");

	// Only data results carry a byte.
	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_DATA |-> data_byte == 8'd0)
		else $error("byte on a non-data result");

	// Only error results carry an error code.
	a_nocode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_ERR |-> error_code == ERR_INVALID)
		else $error("error code on a non-error result");

	// A beat that is not the last of its character is followed by more data.
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> res_valid && kind == KIND_DATA)
		else $error("data run broken before last");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) &&
			$stable(data_byte) && $stable(error_code) && $stable(last))
		else $error("stalled result changed");

endmodule

bind base64_field_decoder b64fd_checker u_b64fd_checker (.*);

>>> tb/tb_base64_field_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_field_decoder: self-checking bench for the base64 field decoder
// Streams zone-file field text into the decoder and predicts every data byte,
// end marker and error. Each result beat is checked against the oldest
// prediction. Both handshake sides idle at random, apart from one long stretch
// in which neither side idles.
// ----------------------------------------------------------------------------
module tb_base64_field_decoder;
	import b64fd_pkg::*;

	localparam int DEPTH_MAX   = 15;
	localparam int CYCLE_LIMIT = 400000;
	localparam int CHAR_TARGET = 500;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] code;
		logic       last;
	} dec_result_t;

	// Tracks the decoder state and the results still owed by the block.
	class decode_checker;
		logic [17:0]  quad_bits = '0;
		logic [1:0]   quad_len = '0;
		logic [1:0]   quad_pads = '0;
		int           paren_level;
		bit           skipping_comment;
		int           errors;
		dec_result_t  owed_results[$];

		function void add(logic [1:0] k, logic [7:0] d, logic [1:0] e, logic l);
			dec_result_t r;
			r.kind = k;
			r.data = d;
			r.code = e;
			r.last = l;
			owed_results.push_back(r);
		endfunction

		function void drop_quartet();
			quad_bits = '0;
			quad_len  = '0;
			quad_pads = '0;
		endfunction

		function void add_error(logic [1:0] e);
			drop_quartet();
			add(KIND_ERR, 8'h00, e, 1'b1);
		endfunction

		// Works out the results of one accepted character and advances the state.
		function void note_char(logic [7:0] c);
			logic [5:0]  sx;
			logic        in_alpha;
			logic [23:0] word;
			int          n;
			sx       = '0;
			in_alpha = 1'b1;

			// Line breaks end the field unless a parenthesis is open.
			if (c == CH_CR || c == CH_LF) begin
				skipping_comment = 1'b0;
				if (paren_level != 0)
					return;
				if (quad_len != 0) begin
					add_error(ERR_DANGLING);
					return;
				end
				drop_quartet();
				add(KIND_END, 8'h00, ERR_INVALID, 1'b1);
				return;
			end
			if (skipping_comment)
				return;
			if (c == CH_SEMI) begin
				skipping_comment = 1'b1;
				return;
			end
			if (c == CH_SPACE || c == CH_TAB)
				return;

			// Parenthesis nesting saturates at the maximum depth.
			if (c == CH_OPEN) begin
				if (paren_level >= DEPTH_MAX) begin
					paren_level = DEPTH_MAX;
					add_error(ERR_DEPTH);
					return;
				end
				paren_level++;
				return;
			end
			if (c == CH_CLOSE) begin
				if (paren_level == 0) begin
					add_error(ERR_PAREN);
					return;
				end
				paren_level--;
				return;
			end

			// Alphabet decode and padding rules.
			if (c >= "A" && c <= "Z")
				sx = 6'(c - "A");
			else if (c >= "a" && c <= "z")
				sx = 6'(c - "a" + 26);
			else if (c >= "0" && c <= "9")
				sx = 6'(c - "0" + 52);
			else if (c == CH_PLUS)
				sx = 6'd62;
			else if (c == CH_SLASH)
				sx = 6'd63;
			else
				in_alpha = 1'b0;

			if (c == CH_PAD) begin
				if (quad_len < 2) begin
					add_error(ERR_INVALID);
					return;
				end
				quad_pads++;
				sx = '0;
			end else if (!in_alpha || quad_pads != 0) begin
				add_error(ERR_INVALID);
				return;
			end

			if (quad_len < 3) begin
				quad_bits = {quad_bits[11:0], sx};
				quad_len++;
				return;
			end

			// A full quartet yields one to three bytes, the last one flagged.
			word = {quad_bits, sx};
			n    = 3 - quad_pads;
			for (int k = 0; k < n; k++)
				add(KIND_DATA, word[23 - 8 * k -: 8], ERR_INVALID, k == n - 1);
			drop_quartet();
		endfunction

		// Compares one result beat with the oldest owed result.
		function void check_result(logic [1:0] k, logic [7:0] d, logic [1:0] e, logic l);
			dec_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected k=%0d b=%02h c=%0d l=%0b",
					$time, k, d, e, l);
				return;
			end
			want = owed_results.pop_front();
			if (want.kind !== k || want.data !== d || want.code !== e || want.last !== l) begin
				errors++;
				$display("%0t: exp k=%0d b=%02h c=%0d l=%0b, got k=%0d b=%02h c=%0d l=%0b",
					$time, want.kind, want.data, want.code, want.last, k, d, e, l);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] char_byte;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [1:0] error_code;
	logic       last;

	decode_checker sb = new;
	int            chars_counted;
	int            cycle_count = 0;
	bit            steady;

	base64_field_decoder #(
		.MAX_PAREN_DEPTH(DEPTH_MAX)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_byte  (char_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.error_code (error_code),
		.last       (last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls at random except during the steady stretch.
	always @(negedge clk) begin
		if (!arst_n || steady)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(0, 99) < 37);
	end

	// Every accepted result beat is checked.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(kind, data_byte, error_code, last);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sends one character beat; entered and left at a falling edge.
	task automatic send_char(input logic [7:0] c);
		if (!steady) begin
			while ($urandom_range(0, 99) < 37) begin
				char_valid <= 1'b0;
				@(negedge clk);
			end
		end
		if (!(c == CH_SPACE || c == CH_TAB || sb.skipping_comment))
			chars_counted++;
		char_valid <= 1'b1;
		char_byte  <= c;
		do @(posedge clk); while (char_stall);
		sb.note_char(c);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] b64_char(input int v);
		if (v < 26)
			return 8'(65 + v);
		if (v < 52)
			return 8'(97 + v - 26);
		if (v < 62)
			return 8'(48 + v - 52);
		return (v == 62) ? CH_PLUS : CH_SLASH;
	endfunction

	// Brings the decoder back to the start of a field.
	task automatic settle_field();
		if (sb.skipping_comment)
			send_char(CH_LF);
		while (sb.paren_level > 0)
			send_char(CH_CLOSE);
		if (sb.quad_len != 0)
			send_char(CH_LF);
	endtask

	task automatic send_comment_text();
		logic [7:0] c;
		repeat ($urandom_range(0, 4)) begin
			do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
			send_char(c);
		end
	endtask

	// Optional filler between quartet characters.
	task automatic send_filler();
		case ($urandom_range(0, 11))
			0: send_char(CH_SPACE);
			1: send_char(CH_TAB);
			2: begin
				send_char(CH_OPEN);
				send_char(CH_SEMI);
				send_comment_text();
				send_char(CH_LF);
				send_char(CH_CLOSE);
			end
			3: begin
				send_char(CH_OPEN);
				send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
				send_char(CH_CLOSE);
			end
			default: ;
		endcase
	endtask

	// A well-formed field: whole quartets, the last one maybe padded.
	task automatic send_good_field();
		int nq;
		int pads;
		settle_field();
		nq   = $urandom_range(1, 4);
		pads = $urandom_range(0, 2);
		for (int q = 0; q < nq; q++) begin
			for (int p = 0; p < 4; p++) begin
				if (q == nq - 1 && p >= 4 - pads)
					send_char(CH_PAD);
				else
					send_char(b64_char($urandom_range(0, 63)));
				send_filler();
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			send_char(CH_SEMI);
			send_comment_text();
		end
		send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	task automatic send_paren_burst(input int n);
		repeat (n) send_char(CH_OPEN);
		settle_field();
	endtask

	// Fields, most of them broken in one of the ways the decoder reports.
	task automatic send_bad_field();
		settle_field();
		case ($urandom_range(0, 4))
			0: begin
				repeat ($urandom_range(1, 7)) send_char(b64_char($urandom_range(0, 63)));
				send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
			end
			1: begin
				repeat ($urandom_range(0, 1)) send_char(b64_char($urandom_range(0, 63)));
				send_char(CH_PAD);
			end
			2: begin
				send_char(b64_char($urandom_range(0, 63)));
				send_char(b64_char($urandom_range(0, 63)));
				send_char(CH_PAD);
				send_char(b64_char($urandom_range(0, 63)));
			end
			3: send_char(CH_CLOSE);
			default: send_paren_burst($urandom_range(13, 17));
		endcase
	endtask

	// Random bytes of any value.
	task automatic send_noise();
		repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
	endtask

	// Main stimulus sequence.
	initial begin
		arst_n        = 1'b0;
		char_valid    = 1'b0;
		char_byte     = 8'h00;
		steady        = 1'b0;
		chars_counted = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: byte extremes, padding forms, every error, and the tab, parenthesis and comment skips.
		send_text("A//+TQ==\n");
		send_text("TWE=\tAb");
		send_char(CH_CR);
		send_text(")=AB=C");
		send_char(8'hFF);
		send_text("(\n)");
		send_text(";\n");
		send_paren_burst(DEPTH_MAX + 1);

		// Random fields, mostly well-formed.
		while (chars_counted < CHAR_TARGET) begin
			steady = (chars_counted >= 200 && chars_counted < 300);
			case ($urandom_range(0, 19))
				0, 1, 2:  send_noise();
				3, 4, 5:  send_bad_field();
				default:  send_good_field();
			endcase
		end
		steady = 1'b0;
		char_valid <= 1'b0;

		// Drain the owed results, then give the block time for strays.
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/b64fd_pkg.sv
rtl/core/base64_field_decoder.sv
rtl/core/b64fd_checker.sv
tb/tb_base64_field_decoder.sv
